>>> design/sorted_set_insert_with_median_top_defines.svh
// assertion helpers for the sorted set block
`ifndef SORTED_SET_INSERT_WITH_MEDIAN_TOP_DEFINES_SVH
`define SORTED_SET_INSERT_WITH_MEDIAN_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define SSIM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted set check failed");
// next-cycle implication, checked outside reset
`define SSIM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted set check failed");
`else
`define SSIM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SSIM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> design/ssim_pkg.sv
package ssim_pkg;

    localparam int VALUE_W      = 32;
    localparam int COUNT_W      = 7;
    localparam int STATUS_W     = 2;
    localparam int CAPACITY_DEF = 64;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    // compare results of one cell
    typedef struct packed {
        logic lt;
        logic eq;
    } cell_flags_t;

    // controls broadcast to every cell
    typedef struct packed {
        logic insert;
        logic load_mid;
    } cell_ctrl_t;

endpackage

>>> design/sorted_set_insert_with_median_top.sv
// Sorted set with running median. Each item offers one signed 32-bit value;
// a value not yet held is inserted in ascending order, a held value is
// rejected as a duplicate (this test wins even when full), and a new value
// into a full store is refused. Each item returns one result: status, count
// after the item and the median, the entry at sorted index count/2 (upper
// median for even counts, zero when empty). Storage is a row of CAPACITY
// cells; every cell compares its entry with the incoming value in parallel
// and either keeps its entry, takes the new value or takes its left
// neighbor's entry, so an insert finishes at the accepting edge. A one-hot
// middle marker moves with the count. The median is selected from the
// registered cells in the following cycle and loaded into the output
// register when it can take it; one item per cycle is sustained while the
// output is not stalled. Entry storage has no reset; only held cells are
// ever compared or selected. Count wraps to 7 bits if CAPACITY exceeds 127.
module sorted_set_insert_with_median_top
    import ssim_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [VALUE_W-1:0]  value,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic        [STATUS_W-1:0] status,
    output logic        [COUNT_W-1:0]  count,
    output logic signed [VALUE_W-1:0]  median
);

`include "sorted_set_insert_with_median_top_defines.svh"

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // handshake and pending-result control
    logic busy_reg;
    logic out_valid_reg;
    logic in_fire;
    logic out_load;

    // occupancy
    logic [CNT_W-1:0] entry_count_reg;
    logic [CNT_W-1:0] entry_count_next;

    // status waiting for its median
    status_t status_pend_reg;
    status_t status_pend_next;

    // output register
    logic [STATUS_W-1:0]       status_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic signed [VALUE_W-1:0] median_reg;

    // cell row wiring
    cell_ctrl_t                cell_ctrl;
    cell_flags_t               flags     [CAPACITY];
    logic signed [VALUE_W-1:0] entries   [CAPACITY];
    logic        [VALUE_W-1:0] sel_entry [CAPACITY];
    logic [CAPACITY-1:0]       eq_vec;
    logic [CAPACITY-1:0]       mid_vec;

    logic                      dup;
    logic                      full;
    logic                      ins;
    logic [VALUE_W-1:0]        median_sel;
    logic [CNT_W+COUNT_W-1:0]  count_wide;

    // a new item may enter unless a finished result cannot move out
    assign out_load = busy_reg && (!out_valid_reg || !out_stall);
    assign in_stall = busy_reg && out_valid_reg && out_stall;
    assign in_fire  = in_valid && !in_stall;

    assign dup  = |eq_vec;
    assign full = (entry_count_reg >= CNT_W'(CAPACITY));
    assign ins  = in_fire && !dup && !full;

    assign cell_ctrl.insert   = ins;
    assign cell_ctrl.load_mid = in_fire;

    always_comb
    begin
        entry_count_next = entry_count_reg;
        status_pend_next = status_pend_reg;
        if (in_fire)
        begin
            if (dup)
            begin
                status_pend_next = ST_DUPLICATE;
            end
            else if (full)
            begin
                status_pend_next = ST_FULL;
            end
            else
            begin
                status_pend_next = ST_INSERTED;
                entry_count_next = entry_count_reg + CNT_W'(1);
            end
        end
    end

    // the chain of cells, cell 0 sees an always-below left neighbor
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                      left_lt;
        logic signed [VALUE_W-1:0] left_entry;
        logic                      occupied;
        logic                      mid_set;

        if (i == 0)
        begin : g_first
            assign left_lt    = 1'b1;
            assign left_entry = value;
        end
        else
        begin : g_rest
            assign left_lt    = flags[i-1].lt;
            assign left_entry = entries[i-1];
        end

        assign occupied = (CNT_W'(i) < entry_count_reg);
        // middle marker follows the count after this item
        assign mid_set  = ((entry_count_next >> 1) == CNT_W'(i));
        assign eq_vec[i] = flags[i].eq;

        ssim_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl),
            .value      (value),
            .occupied   (occupied),
            .left_lt    (left_lt),
            .left_entry (left_entry),
            .mid_set    (mid_set),
            .flags      (flags[i]),
            .entry      (entries[i]),
            .mid        (mid_vec[i]),
            .sel_entry  (sel_entry[i])
        );
    end

    // one-hot select of the middle cell
    always_comb
    begin
        median_sel = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            median_sel = median_sel | sel_entry[i];
        end
        if (entry_count_reg == '0)
        begin
            median_sel = '0;
        end
    end

    assign count_wide = {{COUNT_W{1'b0}}, entry_count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            entry_count_reg <= '0;
            status_pend_reg <= ST_INSERTED;
        end
        else
        begin
            busy_reg        <= in_fire || (busy_reg && !out_load);
            out_valid_reg   <= out_load || (out_valid_reg && out_stall);
            entry_count_reg <= entry_count_next;
            status_pend_reg <= status_pend_next;
        end
    end

    // cells and count already hold the pending item's outcome here
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg <= status_pend_reg;
            count_reg  <= count_wide[COUNT_W-1:0];
            median_reg <= median_sel;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign count     = count_reg;
    assign median    = median_reg;

    // occupancy never passes the capacity
    `SSIM_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, entry_count_reg <= CNT_W'(CAPACITY))
    // at most one middle marker
    `SSIM_ASSERT_NOW(a_mid_onehot, clk, rst_n, 1'b1, $onehot0(mid_vec))
    // a held value is never inserted twice
    `SSIM_ASSERT_NOW(a_dup_no_insert, clk, rst_n, dup, !ins)
    // an insert grows the count by exactly one
    `SSIM_ASSERT_NEXT(a_insert_count, clk, rst_n, ins, entry_count_reg == $past(entry_count_reg) + CNT_W'(1))
    // a pending result reaches the output once it can move
    `SSIM_ASSERT_NEXT(a_result_out, clk, rst_n, out_load, out_valid_reg)

endmodule

>>> design/ssim_cell.sv
module ssim_cell
    import ssim_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cell_ctrl_t                ctrl,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      occupied,
    input  logic                      left_lt,
    input  logic signed [VALUE_W-1:0] left_entry,
    input  logic                      mid_set,
    output cell_flags_t               flags,
    output logic signed [VALUE_W-1:0] entry,
    output logic                      mid,
    output logic        [VALUE_W-1:0] sel_entry
);

    logic signed [VALUE_W-1:0] entry_reg;
    logic signed [VALUE_W-1:0] entry_next;
    logic                      mid_reg;

    // only held entries take part in the compare
    assign flags.lt = occupied && (entry_reg < value);
    assign flags.eq = occupied && (entry_reg == value);

    // on an insert keep when below the new value, else take the new value or shift right; otherwise keep
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.insert && !flags.lt)
        begin
            entry_next = left_lt ? value : left_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg <= 1'b0;
        end
        else if (ctrl.load_mid)
        begin
            mid_reg <= mid_set;
        end
    end

    assign entry     = entry_reg;
    assign mid       = mid_reg;
    assign sel_entry = mid_reg ? entry_reg : '0;

endmodule

>>> tb/sorted_set_insert_with_median_top_test.sv
module sorted_set_insert_with_median_top_test;
    import ssim_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // store size used for this run, also the depth of the shadow copy
    localparam int SET_CAP = CAPACITY_DEF;
    // random items after the directed table
    localparam int RAND_ITEMS = 1430;
    // cycles with no item moving on either side before the run is abandoned
    localparam int WATCHDOG_LIMIT = 2000;
    // settle cycles after the last result
    localparam int DRAIN_TAIL = 8;
    // long receiver hold-off, starts once this many items went in
    localparam int HOLD_AFTER = 500;
    localparam int HOLD_CYCLES = 160;

    localparam logic [VALUE_W-1:0] V_MIN = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] V_MAX = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] V_NEG1 = 32'hFFFF_FFFF;

    // one result of the block
    typedef struct packed {
        status_t              st;
        logic [COUNT_W-1:0]   cnt;
        logic [VALUE_W-1:0]   med;
    } median_result_t;

    // one row of the directed table, res only meaningful when typed is set
    typedef struct packed {
        logic [VALUE_W-1:0]   v;
        logic                 typed;
        median_result_t       res;
    } dir_row_t;

    localparam int DIR_N = 19;

    // starts from the empty store right after reset; the first rows are
    // simple enough to write the answer down, the rest go through the
    // predictor
    localparam dir_row_t DIR_TABLE [DIR_N] = '{
        // first insert, median is the only entry
        '{32'h0000_0000, 1'b1, '{ST_INSERTED,  7'd1, 32'h0000_0000}},
        // same value again is a duplicate, nothing moves
        '{32'h0000_0000, 1'b1, '{ST_DUPLICATE, 7'd1, 32'h0000_0000}},
        // most positive value goes to the top, upper median of two
        '{V_MAX,         1'b1, '{ST_INSERTED,  7'd2, V_MAX}},
        // most negative value goes to the bottom
        '{V_MIN,         1'b1, '{ST_INSERTED,  7'd3, 32'h0000_0000}},
        '{V_MAX,         1'b1, '{ST_DUPLICATE, 7'd3, 32'h0000_0000}},
        '{V_MIN,         1'b1, '{ST_DUPLICATE, 7'd3, 32'h0000_0000}},
        '{V_NEG1,        1'b1, '{ST_INSERTED,  7'd4, 32'h0000_0000}},
        '{32'h0000_0001, 1'b1, '{ST_INSERTED,  7'd5, 32'h0000_0000}},
        '{32'h8000_0001, 1'b0, '{ST_INSERTED,  7'd0, 32'h0000_0000}},
        '{32'h7FFF_FFFE, 1'b0, '{ST_INSERTED,  7'd0, 32'h0000_0000}},
        '{32'h5555_5555, 1'b0, '{ST_INSERTED,  7'd0, 32'h0000_0000}},
        '{32'hAAAA_AAAA, 1'b0, '{ST_INSERTED,  7'd0, 32'h0000_0000}},
        '{32'hAAAA_AAAA, 1'b0, '{ST_INSERTED,  7'd0, 32'h0000_0000}},
        '{32'h0000_0002, 1'b0, '{ST_INSERTED,  7'd0, 32'h0000_0000}},
        '{32'hFFFF_FFFE, 1'b0, '{ST_INSERTED,  7'd0, 32'h0000_0000}},
        '{32'h0001_0000, 1'b0, '{ST_INSERTED,  7'd0, 32'h0000_0000}},
        '{32'hFFFF_0000, 1'b0, '{ST_INSERTED,  7'd0, 32'h0000_0000}},
        '{32'h0000_0001, 1'b0, '{ST_INSERTED,  7'd0, 32'h0000_0000}},
        '{V_MAX,         1'b0, '{ST_INSERTED,  7'd0, 32'h0000_0000}}
    };

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic signed [VALUE_W-1:0]  value = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic        [STATUS_W-1:0] status;
    logic        [COUNT_W-1:0]  count;
    logic signed [VALUE_W-1:0]  median;

    // shadow copy of the sorted store, ascending, no repeats
    logic [VALUE_W-1:0] shadow_set [SET_CAP];
    int                 shadow_n = 0;

    // results still owed by the block, oldest first
    median_result_t     pending_results [$];

    int                 err_cnt = 0;
    int                 items_in = 0;
    int                 idle_cycles = 0;

    // receiver pattern state
    int                 stall_mode = 0;
    int                 mode_left = 0;
    int                 hold_left = 0;
    bit                 hold_done = 1'b0;

    sorted_set_insert_with_median_top #(
        .CAPACITY (SET_CAP)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .count     (count),
        .median    (median)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // insert one value into the shadow set and work out the block's answer
    function automatic median_result_t insert_and_median(input logic [VALUE_W-1:0] v);
        median_result_t r;
        int             pos;
        int             i;
        pos = 0;
        // first slot whose entry is not below v
        while (pos < shadow_n && $signed(shadow_set[pos]) < $signed(v))
            pos++;
        if (pos < shadow_n && shadow_set[pos] == v)
        begin
            // duplicate check wins even with a full store
            r.st = ST_DUPLICATE;
        end
        else if (shadow_n >= SET_CAP)
        begin
            r.st = ST_FULL;
        end
        else
        begin
            for (i = shadow_n; i > pos; i--)
                shadow_set[i] = shadow_set[i-1];
            shadow_set[pos] = v;
            shadow_n++;
            r.st = ST_INSERTED;
        end
        r.cnt = COUNT_W'(shadow_n);
        // upper median, zero for an empty store
        r.med = (shadow_n > 0) ? shadow_set[shadow_n / 2] : '0;
        return r;
    endfunction

    // random value, biased toward held values and a narrow band so that
    // duplicates are frequent and the store fills gradually
    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (shadow_n > 0 && r < 40)
            return shadow_set[$urandom_range(0, shadow_n - 1)];
        if (r < 48)
        begin
            case ($urandom_range(0, 3))
                0: return V_MIN;
                1: return V_MAX;
                2: return '0;
                default: return V_NEG1;
            endcase
        end
        if (r < 75)
            return VALUE_W'($signed($urandom_range(0, 600)) - 300);
        return $urandom;
    endfunction

    // present one item and hold it until taken; expectation is queued at
    // the accepting edge
    task automatic offer_item(input logic [VALUE_W-1:0] v, input logic typed,
                              input median_result_t typed_res);
        median_result_t p;
        in_valid <= 1'b1;
        value    <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        p = insert_and_median(v);
        pending_results.push_back(typed ? typed_res : p);
        items_in++;
    endtask

    // sender: directed table first, then random items in bursts
    initial
    begin
        int burst_left;
        int gap;
        int k;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows go back to back
        for (k = 0; k < DIR_N; k++)
            offer_item(DIR_TABLE[k].v, DIR_TABLE[k].typed, DIR_TABLE[k].res);

        burst_left = 0;
        for (k = 0; k < RAND_ITEMS; k++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                // about a quarter of the bursts follow with no gap at all
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
            offer_item(pick_value(), 1'b0, '0);
        end
        in_valid <= 1'b0;

        // drain, then let the pipeline settle so a stray result shows up
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);

        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // receiver: check each accepted result, then choose the next stall
    always @(posedge clk)
    begin
        median_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected: status %0d count %0d median %0d",
                       status, count, median);
                err_cnt++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (status !== e.st)
                begin
                    $error("status mismatch: expected %0d, actual %0d", e.st, status);
                    err_cnt++;
                end
                if (count !== e.cnt)
                begin
                    $error("count mismatch: expected %0d, actual %0d", e.cnt, count);
                    err_cnt++;
                end
                if (median !== e.med)
                begin
                    $error("median mismatch: expected %0d, actual %0d",
                           $signed(e.med), median);
                    err_cnt++;
                end
            end
        end

        // one long hold-off while the sender keeps offering, so the block
        // backs up and stalls its input
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (!hold_done && items_in >= HOLD_AFTER)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            // stretches of no stall, light, medium and heavy stall
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(10, 60);
            end
            mode_left--;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 1) == 0);
                default: out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // watchdog on cycles where no item moves on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule

>>> filelist.f
+incdir+design
design/ssim_pkg.sv
design/ssim_cell.sv
design/sorted_set_insert_with_median_top.sv
tb/sorted_set_insert_with_median_top_test.sv
